/* rtl/pgl_pkg.sv */
// shared types and constants for the periodic grid laplacian unit
package pgl_pkg;

   localparam int MAX_X_DEF = 16;
   localparam int MAX_Y_DEF = 16;
   localparam int MAX_Z_DEF = 16;

   localparam int COORD_W    = 4;
   localparam int SIZE_W     = 5;
   localparam int DENS_W     = 16;
   localparam int INV_W      = 16;
   localparam int LAP_W      = 28;
   localparam int ACC_W      = 20;
   localparam int PROD_W     = ACC_W + INV_W + 1;
   localparam int FRAC_BITS  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W     = 3;

   localparam int CENTRE_WEIGHT = 6;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
   localparam logic [INV_W-1:0]  INV_RESET  = INV_W'(256);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SQ = 2'd3;

   localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_XM     = 3'd1;
   localparam logic [STEP_W-1:0] STEP_XP     = 3'd2;
   localparam logic [STEP_W-1:0] STEP_YM     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_YP     = 3'd4;
   localparam logic [STEP_W-1:0] STEP_ZM     = 3'd5;
   localparam logic [STEP_W-1:0] STEP_ZP     = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_DRAIN,
      S_MUL,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic acc_en;
      logic acc_centre;
      logic mul_en;
   } ctl_type;

   typedef struct packed {
      logic emit;
      logic bad;
   } done_type;

endpackage

/* rtl/pgl_if.sv */
// request and response channel interfaces
interface pgl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [pgl_pkg::COORD_W-1:0]  cell_x;
   logic [pgl_pkg::COORD_W-1:0]  cell_y;
   logic [pgl_pkg::COORD_W-1:0]  cell_z;
   logic [pgl_pkg::DENS_W-1:0]   density;

   modport source (output valid, output req_type, output cell_x, output cell_y,
                   output cell_z, output density, input ready);
   modport sink (input valid, input req_type, input cell_x, input cell_y,
                 input cell_z, input density, output ready);
endinterface

interface pgl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pgl_pkg::LAP_W-1:0]  laplacian;
   logic                              bad_coordinate;

   modport source (output valid, output laplacian, output bad_coordinate, input ready);
   modport sink (input valid, input laplacian, input bad_coordinate, output ready);
endinterface

/* rtl/pgl_store.sv */
// single-port density grid memory with registered read data
module pgl_store #(
   parameter int DEPTH = pgl_pkg::MAX_X_DEF * pgl_pkg::MAX_Y_DEF * pgl_pkg::MAX_Z_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic                        re,
   input  logic [AW-1:0]               addr,
   input  logic [pgl_pkg::DENS_W-1:0]  wdata,
   output logic [pgl_pkg::DENS_W-1:0]  rdata
);
   import pgl_pkg::*;

   logic [DENS_W-1:0] mem [DEPTH];
   logic [DENS_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/pgl_calc.sv */
// shared accumulator and scaling multiplier
module pgl_calc (
   input  logic                              clock,
   input  pgl_pkg::ctl_type                  ctl,
   input  logic [pgl_pkg::DENS_W-1:0]        rd_data,
   input  logic [pgl_pkg::INV_W-1:0]         inv_sq,
   output logic signed [pgl_pkg::LAP_W-1:0]  laplacian
);
   import pgl_pkg::*;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  sample;

   always_comb begin
      sample = $signed(ACC_W'(rd_data));
      if (ctl.acc_centre) begin
         acc_in = ACC_W'(0) - sample * $signed(ACC_W'(CENTRE_WEIGHT));
      end else begin
         acc_in = acc_ff + sample;
      end
      prod_in = PROD_W'(acc_ff) * $signed(PROD_W'({1'b0, inv_sq}));
   end

   always_ff @(posedge clock) begin
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // floor shift by the fraction bits
   assign laplacian = prod_ff[LAP_W+FRAC_BITS-1:FRAC_BITS];

endmodule

/* rtl/pgl_seq.sv */
// request sequencer: range check, neighbor addressing and read schedule
module pgl_seq #(
   parameter int MAX_X = pgl_pkg::MAX_X_DEF,
   parameter int MAX_Y = pgl_pkg::MAX_Y_DEF,
   parameter int MAX_Z = pgl_pkg::MAX_Z_DEF,
   parameter int AW    = $clog2(MAX_X * MAX_Y * MAX_Z)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [pgl_pkg::COORD_W-1:0]  cell_x,
   input  logic [pgl_pkg::COORD_W-1:0]  cell_y,
   input  logic [pgl_pkg::COORD_W-1:0]  cell_z,
   input  logic [pgl_pkg::DENS_W-1:0]   density,
   input  logic [pgl_pkg::SIZE_W-1:0]   size_x,
   input  logic [pgl_pkg::SIZE_W-1:0]   size_y,
   input  logic [pgl_pkg::SIZE_W-1:0]   size_z,
   input  logic                         rsp_free,
   output logic                         mem_we,
   output logic                         mem_re,
   output logic [AW-1:0]                mem_addr,
   output logic [pgl_pkg::DENS_W-1:0]   mem_wdata,
   output pgl_pkg::ctl_type             ctl,
   output pgl_pkg::done_type            done
);
   import pgl_pkg::*;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               type_ff, type_in;
   logic [SIZE_W-1:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [DENS_W-1:0]  dens_ff, dens_in;
   logic               bad_ff, bad_in;
   logic               rd_valid_ff, rd_centre_ff;
   logic               mul_en;
   logic               emit;

   logic [SIZE_W-1:0]  sx, sy, sz;
   logic [SIZE_W-1:0]  xm, xp, ym, yp, zm, zp;
   logic               bad_now;
   logic [AW-1:0]      addr_mux;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                  input int lim);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = SIZE_W'(1);
      end else if (32'(s) > lim) begin
         r = SIZE_W'(lim);
      end else begin
         r = s;
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [SIZE_W-1:0] x,
                                               input logic [SIZE_W-1:0] y,
                                               input logic [SIZE_W-1:0] z);
      int a;
      a = int'(x) + MAX_X * (int'(y) + MAX_Y * int'(z));
      return a[AW-1:0];
   endfunction

   always_comb begin
      sx = eff_size(size_x, MAX_X);
      sy = eff_size(size_y, MAX_Y);
      sz = eff_size(size_z, MAX_Z);
      bad_now = (x_ff >= sx) || (y_ff >= sy) || (z_ff >= sz);
      xm = (x_ff == '0) ? sx - SIZE_W'(1) : x_ff - SIZE_W'(1);
      xp = (x_ff + SIZE_W'(1) == sx) ? '0 : x_ff + SIZE_W'(1);
      ym = (y_ff == '0) ? sy - SIZE_W'(1) : y_ff - SIZE_W'(1);
      yp = (y_ff + SIZE_W'(1) == sy) ? '0 : y_ff + SIZE_W'(1);
      zm = (z_ff == '0) ? sz - SIZE_W'(1) : z_ff - SIZE_W'(1);
      zp = (z_ff + SIZE_W'(1) == sz) ? '0 : z_ff + SIZE_W'(1);
      addr_mux = cell_addr(x_ff, y_ff, z_ff);
      if (state_ff == S_READ) begin
         case (step_ff)
            STEP_XM: addr_mux = cell_addr(xm, y_ff, z_ff);
            STEP_XP: addr_mux = cell_addr(xp, y_ff, z_ff);
            STEP_YM: addr_mux = cell_addr(x_ff, ym, z_ff);
            STEP_YP: addr_mux = cell_addr(x_ff, yp, z_ff);
            STEP_ZM: addr_mux = cell_addr(x_ff, y_ff, zm);
            STEP_ZP: addr_mux = cell_addr(x_ff, y_ff, zp);
            default: addr_mux = cell_addr(x_ff, y_ff, z_ff);
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      type_in   = type_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      dens_in   = dens_ff;
      bad_in    = bad_ff;
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mul_en    = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in  = req_type;
               x_in     = SIZE_W'(cell_x);
               y_in     = SIZE_W'(cell_y);
               z_in     = SIZE_W'(cell_z);
               dens_in  = density;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            bad_in = bad_now;
            if (bad_now) begin
               state_in = S_EMIT;
            end else if (type_ff == REQ_WRITE) begin
               mem_we   = 1'b1;
               state_in = S_IDLE;
            end else begin
               step_in  = STEP_CENTRE;
               state_in = S_READ;
            end
         end
         S_READ: begin
            mem_re = 1'b1;
            if (step_ff == STEP_ZP) begin
               state_in = S_DRAIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            mul_en   = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_CENTRE;
         rd_valid_ff  <= 1'b0;
         rd_centre_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rd_valid_ff  <= mem_re;
         rd_centre_ff <= mem_re && (step_ff == STEP_CENTRE);
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      dens_ff <= dens_in;
      bad_ff  <= bad_in;
   end

   assign mem_addr  = addr_mux;
   assign mem_wdata = dens_ff;
   assign ctl       = '{acc_en: rd_valid_ff, acc_centre: rd_centre_ff, mul_en: mul_en};
   assign done      = '{emit: emit, bad: bad_ff};

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_CHECK)
      else $error("accepted request did not enter range check");

   a_last_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ && step_ff == STEP_ZP |=> state_ff == S_DRAIN && ctl.acc_en)
      else $error("seventh read not followed by drain accumulate");

   a_write_good: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == S_CHECK && !bad_now && type_ff == REQ_WRITE)
      else $error("grid written outside a good write request");

endmodule

/* rtl/periodic_grid_laplacian_unit.sv */
// top level of the periodic grid laplacian unit
// Holds a MAX_X x MAX_Y x MAX_Z grid of unsigned Q8.8 density samples with wrap-around
// edges in one single-port memory. A write request with an in-range coordinate returns no
// response. A query request reads the centre and its six neighbors from the grid memory
// one read per cycle, in the steps accept, range check, 7 reads, drain, multiply, response
// register; a request with a coordinate at or above its size answers bad_coordinate with a
// zero laplacian. One request is in flight at a time; a finished response waits in an output
// register while the next request is accepted. The grid is not cleared by reset: a cell
// must be written before any query reads it. The user must write configuration only while
// idle; the block itself does not enforce it.
module periodic_grid_laplacian_unit #(
   parameter int MAX_X = pgl_pkg::MAX_X_DEF,
   parameter int MAX_Y = pgl_pkg::MAX_Y_DEF,
   parameter int MAX_Z = pgl_pkg::MAX_Z_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pgl_req_if.sink                          req,
   pgl_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [pgl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pgl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pgl_pkg::*;

   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int AW    = $clog2(DEPTH);

   logic [SIZE_W-1:0]        size_x_ff, size_y_ff, size_z_ff;
   logic [INV_W-1:0]         inv_sq_ff;
   logic                     rsp_valid_ff;
   logic signed [LAP_W-1:0]  rsp_lap_ff;
   logic                     rsp_bad_ff;

   logic                     mem_we, mem_re;
   logic [AW-1:0]            mem_addr;
   logic [DENS_W-1:0]        mem_wdata, mem_rdata;
   ctl_type                  ctl;
   done_type                 done;
   logic signed [LAP_W-1:0]  lap;
   logic                     rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
         inv_sq_ff <= INV_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_Y: size_y_ff <= csr_wdata[SIZE_W-1:0];
            CSR_SIZE_Z: size_z_ff <= csr_wdata[SIZE_W-1:0];
            CSR_INV_SQ: inv_sq_ff <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   pgl_seq #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y),
      .MAX_Z (MAX_Z),
      .AW    (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_type  (req.req_type),
      .cell_x    (req.cell_x),
      .cell_y    (req.cell_y),
      .cell_z    (req.cell_z),
      .density   (req.density),
      .size_x    (size_x_ff),
      .size_y    (size_y_ff),
      .size_z    (size_z_ff),
      .rsp_free  (rsp_free),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .ctl       (ctl),
      .done      (done)
   );

   pgl_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   pgl_calc u_calc (
      .clock     (clock),
      .ctl       (ctl),
      .rd_data   (mem_rdata),
      .inv_sq    (inv_sq_ff),
      .laplacian (lap)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done.emit) begin
         rsp_bad_ff <= done.bad;
         rsp_lap_ff <= done.bad ? '0 : lap;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.laplacian      = rsp_lap_ff;
   assign rsp.bad_coordinate = rsp_bad_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.bad_coordinate |-> rsp.laplacian == '0)
      else $error("bad coordinate response with nonzero laplacian");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done.emit |-> !rsp_valid_ff || rsp.ready)
      else $error("response register overwritten while pending");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      done.emit |=> rsp.valid)
      else $error("emitted response not presented");

endmodule
